// ----- rtl/owms_pkg.sv -----
// owms_pkg: shared types and constants of the 1-wire master sequencer
// payload structs, phase and register-index codes, rom command bytes
// used by rtl/onewire_master_sequencer.sv and rtl/owms_checker.sv
package owms_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] ResetLowTicksRst      = 16'd500;
  localparam logic [15:0] ResetRecoveryTicksRst = 16'd10000;
  localparam logic [7:0]  OneLowTicksRst        = 8'd1;
  localparam logic [7:0]  SampleTicksRst        = 8'd20;
  localparam logic [7:0]  SlotRestTicksRst      = 8'd50;

  localparam logic [7:0] SkipRom  = 8'hCC;
  localparam logic [7:0] MatchRom = 8'h55;
  localparam logic [3:0] CmdByteIdx = 4'd9;

  typedef enum logic [1:0] {
    ActTick    = 2'd0,
    ActReset   = 2'd1,
    ActByte    = 2'd2,
    ActCommand = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgResetLow      = 3'd0,
    CfgResetRecovery = 3'd1,
    CfgOneLow        = 3'd2,
    CfgSample        = 3'd3,
    CfgSlotRest      = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhRlowP = 3'd1,
    PhRrecP = 3'd2,
    PhRlowC = 3'd3,
    PhRrecC = 3'd4,
    PhSlotX = 3'd5,
    PhSlotC = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        address_valid;
    logic [63:0] rom_address;
    logic        line_in;
  } in_t;

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;
  } out_t;

  // a timing register that holds zero counts as one
  function automatic logic [15:0] at_least_one16(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [7:0] at_least_one8(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// ----- rtl/onewire_master_sequencer.sv -----
// onewire_master_sequencer: 1-wire bus master stepped by one tick per item
// depends on owms_pkg (payload structs, phase codes, rom commands)
//
// Usage:
//   in channel (in_valid_i / in_stall_o / in_data_i): one transfer is one bus
//   tick; action starts a bus reset, a byte exchange or a full command
//   (reset, skip-rom or match-rom with eight address bytes, command byte).
//   out channel (out_valid_o / out_stall_i / out_data_o): one result per
//   input transfer, in order, with the line drive, busy, done, last read
//   byte and a reject flag for a start that came while busy.
//   cfg channel (cfg_valid_i / cfg_ready_o): timing registers, always ready;
//   write only while no tick is in flight.
// Timing:
//   one tick is taken every cycle while in_stall_o is low; its result shows in
//   the output register in the next cycle. All work of a tick is one pass of logic
//   from the state registers into that output register.
//   While a result waits under out_stall_i the output register holds it and
//   in_stall_o is raised, so ticks are throttled with no loss.
// Reset:
//   registers return to their default timings, the sequencer goes idle and
//   the last read byte clears to zero.
module onewire_master_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  owms_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output owms_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [owms_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [owms_pkg::CfgDataW-1:0]      cfg_data_i
);

  // timing registers
  logic [15:0] reset_low_q, reset_rec_q;
  logic [7:0]  one_low_q, sample_q, slot_rest_q;

  // sequencer state
  owms_pkg::phase_e phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bit_idx_q, bit_idx_d;
  logic [3:0]  byte_idx_q, byte_idx_d;
  logic [63:0] held_addr_q, held_addr_d;
  logic [7:0]  held_cmd_q, held_cmd_d;
  logic        held_match_q, held_match_d;
  logic        cur_bit_q, cur_bit_d;
  logic [7:0]  last_read_q, last_read_d;

  logic           out_valid_q;
  owms_pkg::out_t out_data_q, res_d;
  logic           in_xfer;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q <= owms_pkg::ResetLowTicksRst;
      reset_rec_q <= owms_pkg::ResetRecoveryTicksRst;
      one_low_q   <= owms_pkg::OneLowTicksRst;
      sample_q    <= owms_pkg::SampleTicksRst;
      slot_rest_q <= owms_pkg::SlotRestTicksRst;
    end else if (cfg_valid_i) begin
      case (owms_pkg::cfg_idx_e'(cfg_index_i))
        owms_pkg::CfgResetLow:      reset_low_q <= cfg_data_i;
        owms_pkg::CfgResetRecovery: reset_rec_q <= cfg_data_i;
        owms_pkg::CfgOneLow:        one_low_q   <= cfg_data_i[7:0];
        owms_pkg::CfgSample:        sample_q    <= cfg_data_i[7:0];
        owms_pkg::CfgSlotRest:      slot_rest_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [8:0] samp;
    logic [8:0] slot_len;
    logic [2:0] addr_sel;
    phase_d      = phase_q;
    tick_d       = tick_q;
    shift_d      = shift_q;
    bit_idx_d    = bit_idx_q;
    byte_idx_d   = byte_idx_q;
    held_addr_d  = held_addr_q;
    held_cmd_d   = held_cmd_q;
    held_match_d = held_match_q;
    cur_bit_d    = cur_bit_q;
    last_read_d  = last_read_q;
    res_d        = '0;
    samp         = {1'b0, owms_pkg::at_least_one8(sample_q)};
    slot_len     = samp + {1'b0, owms_pkg::at_least_one8(slot_rest_q)};
    addr_sel     = 3'd0;

    // start of an operation, or reject when one is running
    if (owms_pkg::action_e'(in_data_i.action) != owms_pkg::ActTick) begin
      if (phase_q != owms_pkg::PhIdle) begin
        res_d.rejected = 1'b1;
      end else begin
        tick_d = 16'd0;
        case (owms_pkg::action_e'(in_data_i.action))
          owms_pkg::ActReset: begin
            phase_d = owms_pkg::PhRlowP;
          end
          owms_pkg::ActByte: begin
            shift_d   = in_data_i.data_byte;
            bit_idx_d = 3'd0;
            phase_d   = owms_pkg::PhSlotX;
          end
          default: begin
            held_cmd_d   = in_data_i.data_byte;
            held_match_d = in_data_i.address_valid;
            held_addr_d  = in_data_i.rom_address;
            phase_d      = owms_pkg::PhRlowC;
          end
        endcase
      end
    end

    if (phase_d != owms_pkg::PhIdle) begin
      tick_d = tick_d + 16'd1;
      case (phase_d)
        owms_pkg::PhRlowP, owms_pkg::PhRlowC: begin
          res_d.line_low = 1'b1;
          if (tick_d >= owms_pkg::at_least_one16(reset_low_q)) begin
            phase_d = (phase_d == owms_pkg::PhRlowP) ? owms_pkg::PhRrecP
                                                      : owms_pkg::PhRrecC;
            tick_d  = 16'd0;
          end
        end
        owms_pkg::PhRrecP, owms_pkg::PhRrecC: begin
          if (tick_d >= owms_pkg::at_least_one16(reset_rec_q)) begin
            tick_d = 16'd0;
            if (phase_d == owms_pkg::PhRrecP) begin
              phase_d        = owms_pkg::PhIdle;
              res_d.done_res = 1'b1;
            end else begin
              shift_d    = held_match_d ? owms_pkg::MatchRom : owms_pkg::SkipRom;
              byte_idx_d = 4'd0;
              bit_idx_d  = 3'd0;
              phase_d    = owms_pkg::PhSlotC;
            end
          end
        end
        default: begin
          // bit slot
          if (tick_d == 16'd1) begin
            cur_bit_d = shift_d[0];
          end
          res_d.line_low = (tick_d < {7'd0, slot_len}) &&
                           (!cur_bit_d ||
                            tick_d <= {8'd0, owms_pkg::at_least_one8(one_low_q)});
          if (tick_d == {7'd0, samp}) begin
            shift_d = {in_data_i.line_in, shift_d[7:1]};
          end
          if (tick_d >= {7'd0, slot_len}) begin
            tick_d    = 16'd0;
            bit_idx_d = bit_idx_d + 3'd1;
            if (bit_idx_d == 3'd0) begin
              last_read_d = shift_d;
              if (phase_d == owms_pkg::PhSlotX || byte_idx_d >= owms_pkg::CmdByteIdx) begin
                phase_d        = owms_pkg::PhIdle;
                res_d.done_res = 1'b1;
              end else begin
                if (byte_idx_d == 4'd0 && !held_match_d) begin
                  byte_idx_d = owms_pkg::CmdByteIdx;
                end else begin
                  byte_idx_d = byte_idx_d + 4'd1;
                end
                addr_sel = 3'(byte_idx_d - 4'd1);
                if (byte_idx_d >= owms_pkg::CmdByteIdx) begin
                  shift_d = held_cmd_d;
                end else begin
                  shift_d = held_addr_d[{addr_sel, 3'b000} +: 8];
                end
              end
            end
          end
        end
      endcase
    end

    res_d.busy_res  = (phase_d != owms_pkg::PhIdle);
    res_d.read_byte = last_read_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= owms_pkg::PhIdle;
      tick_q       <= '0;
      shift_q      <= '0;
      bit_idx_q    <= '0;
      byte_idx_q   <= '0;
      held_addr_q  <= '0;
      held_cmd_q   <= '0;
      held_match_q <= 1'b0;
      cur_bit_q    <= 1'b0;
      last_read_q  <= '0;
    end else if (in_xfer) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      shift_q      <= shift_d;
      bit_idx_q    <= bit_idx_d;
      byte_idx_q   <= byte_idx_d;
      held_addr_q  <= held_addr_d;
      held_cmd_q   <= held_cmd_d;
      held_match_q <= held_match_d;
      cur_bit_q    <= cur_bit_d;
      last_read_q  <= last_read_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= res_d;
    end
  end

endmodule

// ----- rtl/owms_checker.sv -----
// owms_checker: port-level checks for onewire_master_sequencer
// depends on owms_pkg (payload structs); bound to the top level below
module owms_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input owms_pkg::out_t out_data_o
);

  // busy flag of the last result transfer
  logic prev_busy_q;
  logic out_xfer;

  assign out_xfer = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_busy_q <= 1'b0;
    end else if (out_xfer) begin
      prev_busy_q <= out_data_o.busy_res;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done and busy in one result");

  a_reject_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |-> prev_busy_q)
    else $error("reject while idle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> prev_busy_q)
    else $error("done without a running operation");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind onewire_master_sequencer owms_checker u_owms_checker (.*);

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for onewire_master_sequencer, one tick per transfer
// a scoreboard class predicts every tick result; tasks drive ticks and timing writes
// depends on owms_pkg and rtl/onewire_master_sequencer.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineRandom = 2;

  typedef struct {
    logic [15:0] reset_low;
    logic [15:0] recovery;
    logic [7:0]  one_low;
    logic [7:0]  sample;
    logic [7:0]  slot_rest;
  } timing_t;

  typedef struct {
    owms_pkg::phase_e phase;
    logic [15:0]      tick_count;
    logic [7:0]       shift_reg;
    logic [2:0]       bit_index;
    logic [3:0]       byte_index;
    logic [63:0]      address;
    logic [7:0]       command;
    logic             use_match;
    logic             cur_bit;
    logic [7:0]       last_read;
  } seq_state_t;

  class onewire_scoreboard;
    timing_t        tm;
    seq_state_t     st;
    owms_pkg::out_t expected_ticks[$];
    int             errors;

    function new();
      tm.reset_low  = owms_pkg::ResetLowTicksRst;
      tm.recovery   = owms_pkg::ResetRecoveryTicksRst;
      tm.one_low    = owms_pkg::OneLowTicksRst;
      tm.sample     = owms_pkg::SampleTicksRst;
      tm.slot_rest  = owms_pkg::SlotRestTicksRst;
      st.phase      = owms_pkg::PhIdle;
      st.tick_count = '0;
      st.shift_reg  = '0;
      st.bit_index  = '0;
      st.byte_index = '0;
      st.address    = '0;
      st.command    = '0;
      st.use_match  = 1'b0;
      st.cur_bit    = 1'b0;
      st.last_read  = '0;
      errors        = 0;
    endfunction

    function void set_reg(owms_pkg::cfg_idx_e idx, logic [15:0] val);
      case (idx)
        owms_pkg::CfgResetLow:      tm.reset_low = val;
        owms_pkg::CfgResetRecovery: tm.recovery  = val;
        owms_pkg::CfgOneLow:        tm.one_low   = val[7:0];
        owms_pkg::CfgSample:        tm.sample    = val[7:0];
        owms_pkg::CfgSlotRest:      tm.slot_rest = val[7:0];
        default: ;
      endcase
    endfunction

    // one bus tick: start handling, then advance the running operation
    function void next_bus_tick(inout seq_state_t s, input owms_pkg::in_t it,
                                output owms_pkg::out_t o);
      int unsigned t, rl, rr, one_lo, smp, len;
      rl     = (tm.reset_low == 0) ? 1 : tm.reset_low;
      rr     = (tm.recovery == 0) ? 1 : tm.recovery;
      one_lo = (tm.one_low == 0) ? 1 : tm.one_low;
      smp    = (tm.sample == 0) ? 1 : tm.sample;
      len    = smp + ((tm.slot_rest == 0) ? 1 : tm.slot_rest);
      o = '0;
      if (it.action != owms_pkg::ActTick) begin
        if (s.phase != owms_pkg::PhIdle) begin
          o.rejected = 1'b1;
        end else begin
          case (it.action)
            owms_pkg::ActReset: begin
              s.phase = owms_pkg::PhRlowP;
              s.tick_count = '0;
            end
            owms_pkg::ActByte: begin
              s.shift_reg = it.data_byte;
              s.bit_index = '0;
              s.tick_count = '0;
              s.phase = owms_pkg::PhSlotX;
            end
            default: begin
              s.command = it.data_byte;
              s.use_match = it.address_valid;
              s.address = it.rom_address;
              s.tick_count = '0;
              s.phase = owms_pkg::PhRlowC;
            end
          endcase
        end
      end
      if (s.phase != owms_pkg::PhIdle) begin
        s.tick_count = s.tick_count + 16'd1;
        t = {16'd0, s.tick_count};
        case (s.phase)
          owms_pkg::PhRlowP, owms_pkg::PhRlowC: begin
            o.line_low = 1'b1;
            if (t >= rl) begin
              s.phase = (s.phase == owms_pkg::PhRlowP) ? owms_pkg::PhRrecP
                                                       : owms_pkg::PhRrecC;
              s.tick_count = '0;
            end
          end
          owms_pkg::PhRrecP, owms_pkg::PhRrecC: begin
            if (t >= rr) begin
              s.tick_count = '0;
              if (s.phase == owms_pkg::PhRrecP) begin
                s.phase = owms_pkg::PhIdle;
                o.done_res = 1'b1;
              end else begin
                s.shift_reg = s.use_match ? owms_pkg::MatchRom : owms_pkg::SkipRom;
                s.byte_index = '0;
                s.bit_index = '0;
                s.phase = owms_pkg::PhSlotC;
              end
            end
          end
          default: begin
            if (t == 1) s.cur_bit = s.shift_reg[0];
            o.line_low = (t < len) && (!s.cur_bit || t <= one_lo);
            if (t == smp) s.shift_reg = {it.line_in, s.shift_reg[7:1]};
            if (t >= len) begin
              s.tick_count = '0;
              s.bit_index = s.bit_index + 3'd1;
              if (s.bit_index == 0) begin
                s.last_read = s.shift_reg;
                if (s.phase == owms_pkg::PhSlotX ||
                    s.byte_index >= owms_pkg::CmdByteIdx) begin
                  s.phase = owms_pkg::PhIdle;
                  o.done_res = 1'b1;
                end else begin
                  // skip-rom jumps straight from the rom command to the command byte
                  if (s.byte_index == 0 && !s.use_match) s.byte_index = owms_pkg::CmdByteIdx;
                  else s.byte_index = s.byte_index + 4'd1;
                  if (s.byte_index >= owms_pkg::CmdByteIdx) s.shift_reg = s.command;
                  else s.shift_reg = s.address[(int'(s.byte_index) - 1) * 8 +: 8];
                end
              end
            end
          end
        endcase
      end
      o.busy_res  = (s.phase != owms_pkg::PhIdle);
      o.read_byte = s.last_read;
    endfunction

    function void note_tick(owms_pkg::in_t it);
      owms_pkg::out_t o;
      next_bus_tick(st, it, o);
      expected_ticks.push_back(o);
    endfunction

    function void check_field(string name, logic [7:0] exp, logic [7:0] act);
      if (act !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(owms_pkg::out_t got);
      owms_pkg::out_t exp;
      if (expected_ticks.size() == 0) begin
        $error("result transfer with no tick pending");
        errors++;
        return;
      end
      exp = expected_ticks.pop_front();
      check_field("line_low", exp.line_low, got.line_low);
      check_field("busy_res", exp.busy_res, got.busy_res);
      check_field("done_res", exp.done_res, got.done_res);
      check_field("read_byte", exp.read_byte, got.read_byte);
      check_field("rejected", exp.rejected, got.rejected);
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function bit busy();
      return st.phase != owms_pkg::PhIdle;
    endfunction

    // would a plain tick now finish the running operation
    function bit ends_next();
      seq_state_t     s;
      owms_pkg::out_t o;
      s = st;
      next_bus_tick(s, owms_pkg::in_t'('0), o);
      return o.done_res;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  owms_pkg::in_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [owms_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [owms_pkg::CfgDataW-1:0] cfg_data = '0;
  logic in_stall;
  logic out_valid;
  owms_pkg::out_t out_data;
  logic cfg_ready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int op_ticks = 0;
  onewire_scoreboard board;

  always #4 clk_i = ~clk_i;

  onewire_master_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic owms_pkg::in_t rand_tick();
    owms_pkg::in_t it;
    it.action        = 2'($urandom_range(3));
    it.data_byte     = 8'($urandom_range(255));
    it.address_valid = 1'($urandom_range(1));
    it.rom_address   = {$urandom(), $urandom()};
    it.line_in       = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic put_tick(owms_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    board.note_tick(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(owms_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  // 8-bit registers may carry junk in the upper byte; a stray index must be ignored
  task automatic set_timing(logic [15:0] rl, logic [15:0] rr, logic [15:0] ol,
                            logic [15:0] sm, logic [15:0] sr);
    drain();
    write_reg(owms_pkg::CfgResetLow, rl);
    write_reg(owms_pkg::CfgResetRecovery, rr);
    write_reg(owms_pkg::CfgOneLow, ol);
    write_reg(owms_pkg::CfgSample, sm);
    write_reg(owms_pkg::CfgSlotRest, sr);
    write_reg(owms_pkg::cfg_idx_e'(3'($urandom_range(7, 5))), 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_timing();
    set_timing(16'($urandom_range(6)), 16'($urandom_range(6)),
               {8'($urandom_range(255)), 8'($urandom_range(4))},
               {8'($urandom_range(255)), 8'($urandom_range(4))},
               {8'($urandom_range(255)), 8'($urandom_range(3))});
  endtask

  // start tick of an operation
  task automatic begin_op(owms_pkg::action_e act, logic [7:0] data, logic use_match,
                          logic [63:0] rom, int line_sel);
    owms_pkg::in_t it;
    it = rand_tick();
    it.action = act;
    it.data_byte = data;
    it.address_valid = use_match;
    it.rom_address = rom;
    if (line_sel != LineRandom) it.line_in = line_sel[0];
    put_tick(it);
    op_ticks++;
  endtask

  // keep ticking while busy, at most max_ticks ticks (negative: until over)
  task automatic tick_op(int line_sel, int max_ticks);
    owms_pkg::in_t it;
    int            n;
    n = 0;
    while (board.busy() && (max_ticks < 0 || n < max_ticks)) begin
      it = rand_tick();
      if (line_sel != LineRandom) it.line_in = line_sel[0];
      // a start in the finishing tick is still rejected
      if (board.ends_next() ? ($urandom_range(1) == 0) : ($urandom_range(99) >= 4))
        it.action = owms_pkg::ActTick;
      put_tick(it);
      op_ticks++;
      n++;
    end
  endtask

  // start an operation, then keep ticking until it is over
  task automatic run_op(owms_pkg::action_e act, logic [7:0] data, logic use_match,
                        logic [63:0] rom, int line_sel);
    begin_op(act, data, use_match, rom, line_sel);
    tick_op(line_sel, -1);
  endtask

  task automatic random_ops(int budget);
    owms_pkg::in_t it;
    int            start;
    start = op_ticks;
    while (op_ticks - start < budget) begin
      case ($urandom_range(9))
        0, 1, 2:    run_op(owms_pkg::ActReset, 8'($urandom_range(255)),
                           1'($urandom_range(1)), {$urandom(), $urandom()}, LineRandom);
        3, 4, 5, 6: run_op(owms_pkg::ActByte, 8'($urandom_range(255)),
                           1'($urandom_range(1)), {$urandom(), $urandom()}, LineRandom);
        default:    run_op(owms_pkg::ActCommand, 8'($urandom_range(255)),
                           1'($urandom_range(1)), {$urandom(), $urandom()}, LineRandom);
      endcase
      repeat ($urandom_range(3)) begin
        it = rand_tick();
        it.action = owms_pkg::ActTick;
        put_tick(it);
      end
    end
  endtask

  initial begin
    owms_pkg::in_t it;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 54;
    // reset pulse at its default length, shortened once well under way
    begin_op(owms_pkg::ActReset, 8'h00, 1'b0, '0, LineRandom);
    tick_op(LineRandom, 40);
    drain();
    write_reg(owms_pkg::CfgResetLow, 16'd1);
    write_reg(owms_pkg::CfgResetRecovery, 16'd1);
    cfg_valid <= 1'b0;
    tick_op(LineRandom, -1);
    // byte exchange at default slot timing, shortened after the first sample
    begin_op(owms_pkg::ActByte, 8'($urandom_range(255)), 1'b0, '0, LineRandom);
    tick_op(LineRandom, 30);

    set_timing(16'd1, 16'd1, 16'd1, 16'd2, 16'd1);
    tick_op(LineRandom, -1);
    it = '1;
    it.action = owms_pkg::ActTick;
    put_tick(it);
    it = '0;
    put_tick(it);
    run_op(owms_pkg::ActByte, 8'h00, 1'b0, '0, 1);
    run_op(owms_pkg::ActByte, 8'hFF, 1'b1, '1, 0);
    run_op(owms_pkg::ActCommand, 8'h00, 1'b0, '1, LineRandom);
    run_op(owms_pkg::ActCommand, 8'hFF, 1'b1, '1, 1);
    run_op(owms_pkg::ActReset, 8'hFF, 1'b1, '1, LineRandom);
    // zero in a timing register behaves as one
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_op(owms_pkg::ActByte, 8'($urandom_range(255)), 1'b0, '0, LineRandom);
    run_op(owms_pkg::ActReset, 8'h00, 1'b0, '0, LineRandom);
    run_op(owms_pkg::ActCommand, 8'($urandom_range(255)), 1'b1,
           {$urandom(), $urandom()}, LineRandom);
    // one low time that reaches past the sample point
    set_timing(16'd2, 16'd3, 16'd3, 16'd2, 16'd2);
    run_op(owms_pkg::ActByte, 8'hFF, 1'b0, '0, LineRandom);
    run_op(owms_pkg::ActCommand, 8'($urandom_range(255)), 1'b0, '0, LineRandom);

    random_timing();
    random_ops(30);

    send_idle_pct = 54;
    recv_idle_pct = 13;
    random_timing();
    random_ops(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_timing();
    random_ops(30);

    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && board.pending() != 0; i++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[onewire_master_sequencer] OK");
    end else begin
      $display("[onewire_master_sequencer] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[onewire_master_sequencer] ERROR");
    $finish;
  end

endmodule
